// ===== design/xppe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xppe_pkg
// Shared widths, byte-kind codes, register indexes and types for the
// row/column XOR parity product encoder.
// ----------------------------------------------------------------------------
package xppe_pkg;

  localparam int BYTE_W      = 8;
  localparam int KIND_W      = 2;
  localparam int ROW_WIDTH_W = 6;
  localparam int ROW_COUNT_W = 24;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 24;

  // byte kinds on the result channel
  localparam logic [KIND_W-1:0] KIND_INDEX   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ROWPAR  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_COLPAR  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_ROW_WIDTH = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROW_COUNT = 1'b1;

  // column parity memory commands
  typedef struct packed {
    logic wr_en;   // write one entry, mark it valid
    logic clr_all; // drop all entries back to zero
  } cm_cmd_t;

endpackage

// ===== design/xppe_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xppe_if
// Valid/ready channels: payload byte input and encoded byte output.
// ----------------------------------------------------------------------------
interface xppe_in_if;
  logic                        valid;
  logic                        ready;
  logic [xppe_pkg::BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface xppe_out_if;
  logic                        valid;
  logic                        ready;
  logic [xppe_pkg::BYTE_W-1:0] out_byte;
  logic [xppe_pkg::KIND_W-1:0] byte_kind;
  logic                        last_of_row;
  logic                        last_of_block;

  modport source (output valid, output out_byte, output byte_kind,
                  output last_of_row, output last_of_block, input ready);
  modport sink   (input valid, input out_byte, input byte_kind,
                  input last_of_row, input last_of_block, output ready);
endinterface

// ===== design/xppe_colmem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xppe_colmem
// Column parity store: one-write/one-read synchronous RAM with a valid bit
// per entry; entries not valid read as zero.
// ----------------------------------------------------------------------------
module xppe_colmem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  xppe_pkg::cm_cmd_t           cmd,
  input  logic [AW-1:0]               wr_addr,
  input  logic [xppe_pkg::BYTE_W-1:0] wr_data,
  input  logic [AW-1:0]               rd_addr,
  output logic [xppe_pkg::BYTE_W-1:0] rd_data
);
  import xppe_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_r;
  logic [BYTE_W-1:0] rd_q_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= valid_r[rd_addr];
      if (cmd.clr_all) begin
        valid_r <= '0;
      end else if (cmd.wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// ===== design/xor_product_parity_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_product_parity_encoder
// Row/column XOR parity product encoder. Payload bytes come in row-major;
// each row goes out as big-endian row index bytes, the payload bytes and a
// row parity byte. After the last row a parity row (index = row count,
// column parities, its own row parity) closes the block.
//
//   channel   dir  handshake       payload
//   in_item   in   valid/ready     in_byte[7:0]
//   out_item  out  valid/ready     out_byte[7:0], byte_kind[1:0],
//                                  last_of_row, last_of_block
//   cfg_*     in   cfg_we only     cfg_index[0], cfg_data[23:0]
//
// Sequence: one item in flight at a time. A mid-row item is accepted and
// then sends its payload byte. INDEX_BYTES index bytes precede the first
// item of a row, the row parity byte follows its last, and the parity row
// follows the last of a block; one output byte per cycle unless stalled,
// paced by the column parity RAM's single read port during the sweep.
// Reset: synchronous, active low; column parities clear through per-entry
// valid bits, so no clearing pass is needed.
// Stalls: out_item.ready low with a byte pending freezes the sequencer; the
// output register holds its byte. in_item.ready is high only while idle.
// ----------------------------------------------------------------------------
module xor_product_parity_encoder #(
  parameter int MAX_ROW_WIDTH = 32,
  parameter int INDEX_BYTES   = 3
) (
  input  logic                            clk,
  input  logic                            rst_n,
  xppe_in_if.sink                         in_item,
  xppe_out_if.source                      out_item,
  input  logic                            cfg_we,
  input  logic [xppe_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [xppe_pkg::CFG_DATA_W-1:0] cfg_data
);
  import xppe_pkg::*;

  localparam int AW = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
  localparam int KW = (INDEX_BYTES > 1) ? $clog2(INDEX_BYTES) : 1;
  localparam int CW = ROW_WIDTH_W + 1; // column compare width

  localparam logic [ROW_WIDTH_W-1:0] MAX_W   = ROW_WIDTH_W'(MAX_ROW_WIDTH);
  localparam logic [AW-1:0]          COL_TOP = AW'(MAX_ROW_WIDTH - 1);
  localparam logic [KW-1:0]          K_TOP   = KW'(INDEX_BYTES - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0; // wait for an item
  localparam logic [2:0] S_RIDX = 3'd1; // row index bytes
  localparam logic [2:0] S_PAY  = 3'd2; // payload byte + column RMW
  localparam logic [2:0] S_RPAR = 3'd3; // row parity byte
  localparam logic [2:0] S_PIDX = 3'd4; // parity row index bytes
  localparam logic [2:0] S_COLP = 3'd5; // column parity sweep
  localparam logic [2:0] S_FPAR = 3'd6; // parity row's own parity

  // config registers
  logic [ROW_WIDTH_W-1:0] rw_r;
  logic [ROW_COUNT_W-1:0] rc_r;

  // sequencer state
  logic [2:0]             state_r,   state_nxt;
  logic [BYTE_W-1:0]      byte_r,    byte_nxt;
  logic [AW-1:0]          col_r,     col_nxt;   // column of current item
  logic [AW-1:0]          cpos_r,    cpos_nxt;  // column of next item
  logic [ROW_COUNT_W-1:0] rpos_r,    rpos_nxt;
  logic [BYTE_W-1:0]      rp_r,      rp_nxt;    // running row parity
  logic [KW-1:0]          k_r,       k_nxt;     // index byte, from LSB
  logic [ROW_COUNT_W-1:0] idx_val_r, idx_val_nxt;
  logic [AW-1:0]          j_r,       j_nxt;     // sweep column

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r,  out_byte_nxt;
  logic [KIND_W-1:0] out_kind_r,  out_kind_nxt;
  logic              out_lor_r,   out_lor_nxt;
  logic              out_lob_r,   out_lob_nxt;

  // datapath
  logic [ROW_WIDTH_W-1:0] w_eff;
  logic [ROW_COUNT_W-1:0] rc_eff;
  logic [AW-1:0]          col_eff;
  logic [CW-1:0]          col_inc, j_inc;
  logic                   col_more, j_more, row_more;
  logic [ROW_COUNT_W-1:0] idx_sh;
  logic [BYTE_W-1:0]      idx_byte;
  logic                   accept, emit;

  // column parity RAM
  cm_cmd_t           cm_cmd;
  logic [AW-1:0]     cm_rd_addr;
  logic [BYTE_W-1:0] cm_rd_data;

  xppe_colmem #(
    .DEPTH (MAX_ROW_WIDTH),
    .AW    (AW)
  ) u_colmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cm_cmd),
    .wr_addr (col_r),
    .wr_data (cm_rd_data ^ byte_r),
    .rd_addr (cm_rd_addr),
    .rd_data (cm_rd_data)
  );

  // effective width and count: zero reads as one, width saturates
  always_comb begin
    if (rw_r == '0) begin
      w_eff = ROW_WIDTH_W'(1);
    end else if (rw_r > MAX_W) begin
      w_eff = MAX_W;
    end else begin
      w_eff = rw_r;
    end
  end

  assign rc_eff  = (rc_r == '0) ? ROW_COUNT_W'(1) : rc_r;
  assign col_eff = (ROW_WIDTH_W'(cpos_r) >= MAX_W) ? COL_TOP : cpos_r;

  assign col_inc  = CW'(col_r) + CW'(1);
  assign j_inc    = CW'(j_r) + CW'(1);
  assign col_more = col_inc < CW'(w_eff);
  assign j_more   = j_inc < CW'(w_eff);
  assign row_more = ({1'b0, rpos_r} + (ROW_COUNT_W + 1)'(1)) < {1'b0, rc_eff};

  // big-endian index bytes: k counts down from the top byte
  assign idx_sh   = idx_val_r >> {k_r, 3'b000};
  assign idx_byte = idx_sh[BYTE_W-1:0];

  assign in_item.ready = (state_r == S_IDLE);
  assign accept        = in_item.valid && (state_r == S_IDLE);
  assign emit          = (state_r != S_IDLE) && (!out_valid_r || out_item.ready);

  // RAM read address: the item's column while a row item runs; entry 0
  // ahead of the sweep, then one ahead of the byte being sent
  always_comb begin
    unique case (state_r)
      S_IDLE:  cm_rd_addr = col_eff;
      S_PIDX:  cm_rd_addr = '0;
      S_COLP:  cm_rd_addr = (emit && j_more) ? j_inc[AW-1:0] : j_r;
      default: cm_rd_addr = col_r;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    byte_nxt      = byte_r;
    col_nxt       = col_r;
    cpos_nxt      = cpos_r;
    rpos_nxt      = rpos_r;
    rp_nxt        = rp_r;
    k_nxt         = k_r;
    idx_val_nxt   = idx_val_r;
    j_nxt         = j_r;
    cm_cmd        = '0;
    out_valid_nxt = out_valid_r && !out_item.ready;
    out_byte_nxt  = out_byte_r;
    out_kind_nxt  = out_kind_r;
    out_lor_nxt   = out_lor_r;
    out_lob_nxt   = out_lob_r;

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_lor_nxt   = 1'b0;
      out_lob_nxt   = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          byte_nxt = in_item.in_byte;
          col_nxt  = col_eff;
          if (col_eff == '0) begin
            rp_nxt      = '0;
            k_nxt       = K_TOP;
            idx_val_nxt = rpos_r;
            state_nxt   = S_RIDX;
          end else begin
            state_nxt = S_PAY;
          end
        end
      end
      S_RIDX, S_PIDX: begin
        if (emit) begin
          out_byte_nxt = idx_byte;
          out_kind_nxt = KIND_INDEX;
          rp_nxt       = rp_r ^ idx_byte;
          k_nxt        = k_r - KW'(1);
          if (k_r == '0) begin
            j_nxt     = '0;
            state_nxt = (state_r == S_RIDX) ? S_PAY : S_COLP;
          end
        end
      end
      S_PAY: begin
        if (emit) begin
          out_byte_nxt = byte_r;
          out_kind_nxt = KIND_PAYLOAD;
          rp_nxt       = rp_r ^ byte_r;
          cm_cmd.wr_en = 1'b1;
          if (col_more) begin
            cpos_nxt  = col_inc[AW-1:0];
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_RPAR;
          end
        end
      end
      S_RPAR: begin
        if (emit) begin
          out_byte_nxt = rp_r;
          out_kind_nxt = KIND_ROWPAR;
          out_lor_nxt  = 1'b1;
          rp_nxt       = '0;
          cpos_nxt     = '0;
          if (row_more) begin
            rpos_nxt  = rpos_r + ROW_COUNT_W'(1);
            state_nxt = S_IDLE;
          end else begin
            k_nxt       = K_TOP;
            idx_val_nxt = rc_eff;
            state_nxt   = S_PIDX;
          end
        end
      end
      S_COLP: begin
        if (emit) begin
          out_byte_nxt = cm_rd_data;
          out_kind_nxt = KIND_COLPAR;
          rp_nxt       = rp_r ^ cm_rd_data;
          if (j_more) begin
            j_nxt = j_inc[AW-1:0];
          end else begin
            state_nxt = S_FPAR;
          end
        end
      end
      S_FPAR: begin
        if (emit) begin
          out_byte_nxt   = rp_r;
          out_kind_nxt   = KIND_ROWPAR;
          out_lor_nxt    = 1'b1;
          out_lob_nxt    = 1'b1;
          rp_nxt         = '0;
          rpos_nxt       = '0;
          cm_cmd.clr_all = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cpos_r      <= '0;
      rpos_r      <= '0;
      rp_r        <= '0;
      out_valid_r <= 1'b0;
      rw_r        <= ROW_WIDTH_W'(1);
      rc_r        <= ROW_COUNT_W'(1);
    end else begin
      state_r     <= state_nxt;
      cpos_r      <= cpos_nxt;
      rpos_r      <= rpos_nxt;
      rp_r        <= rp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ROW_WIDTH: rw_r <= cfg_data[ROW_WIDTH_W-1:0];
          CFG_ROW_COUNT: rc_r <= cfg_data[ROW_COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    col_r      <= col_nxt;
    k_r        <= k_nxt;
    idx_val_r  <= idx_val_nxt;
    j_r        <= j_nxt;
    out_byte_r <= out_byte_nxt;
    out_kind_r <= out_kind_nxt;
    out_lor_r  <= out_lor_nxt;
    out_lob_r  <= out_lob_nxt;
  end

  assign out_item.valid         = out_valid_r;
  assign out_item.out_byte      = out_byte_r;
  assign out_item.byte_kind     = out_kind_r;
  assign out_item.last_of_row   = out_lor_r;
  assign out_item.last_of_block = out_lob_r;

endmodule

// ===== design/xppe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xppe_checker
// Port-level checks on the encoder, bound to the top level.
// ----------------------------------------------------------------------------
module xppe_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [xppe_pkg::KIND_W-1:0] byte_kind,
  input logic                        last_of_row,
  input logic                        last_of_block
);
  import xppe_pkg::*;

  // stalled result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // block end only on a row parity byte that also ends a row
  a_lob_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last_of_block |-> last_of_row && (byte_kind == KIND_ROWPAR))
    else $error("last_of_block on a wrong byte");

  // row end flag only on row parity bytes
  a_lor_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last_of_row |-> (byte_kind == KIND_ROWPAR))
    else $error("last_of_row on a wrong byte");

  // one item at a time: no new item right after one is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accept");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind xor_product_parity_encoder xppe_checker u_xppe_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_item.valid),
  .in_ready      (in_item.ready),
  .out_valid     (out_item.valid),
  .out_ready     (out_item.ready),
  .byte_kind     (out_item.byte_kind),
  .last_of_row   (out_item.last_of_row),
  .last_of_block (out_item.last_of_block)
);
